@@ rtl/core/ase_pkg.sv @@
// Package for the argmax accuracy / squared-error evaluator.
// Holds the request and result structs, default sizes and value-kind codes.
// No dependencies.
package ase_pkg;

    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int MAX_FRAMES_DEF   = 65536;

    localparam int COUNT_OUT_W = 17;
    localparam int KIND_W      = 2;

    // raw_output interpretation; the unused code reads as fixed point
    localparam logic [KIND_W-1:0] KIND_FIXED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BIT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [31:0]        raw_output;
        logic signed [31:0] expected_value;
        logic               frame_last;
        logic               dataset_last;
    } item_t;

    typedef struct packed {
        logic                   frame_hit;
        logic [COUNT_OUT_W-1:0] hit_count;
        logic [COUNT_OUT_W-1:0] frame_count;
        logic [63:0]            error_total;
        logic                   dataset_done;
    } result_t;

endpackage

@@ rtl/core/argmax_accuracy_sse_evaluator.sv @@
// Top level of the argmax accuracy / squared-error evaluator.
// Depends on ase_pkg (item_t, result_t, kind codes, defaults).
//
// Usage:
//  - cfg_valid/cfg_ready/cfg_data writes value_kind (0 Q16.16, 1 integer,
//    2 top bit as 0/1; 3 reads as Q16.16). cfg_ready is always high. Write
//    it only while no request is in flight.
//  - item_valid/item_ready/item carries one element request: raw output word,
//    expected Q16.16 value, frame_last and dataset_last marks.
//  - result_valid/result_ready/result returns one result per frame, on the
//    request that carries frame_last: hit flag, hit and frame counts, the
//    saturating Q32.32 error total and the dataset_done mark.
//  - A frame's last request passes the capture, comparison, magnitude, square,
//    frame-close and output registers. Throughput: one request per cycle unless
//    the receiver stalls; the running compare/accumulate stage sets this figure.
//  - When the receiver stalls, the result sits in the output register and the
//    pipeline keeps filling its empty stages; item_ready drops only once the
//    frame-close stage is blocked behind the held result.
//  - Reset clears the element position, maxima, frame error, counts and totals
//    and sets value_kind to Q16.16. Totals also clear after a dataset_done
//    result is produced.
module argmax_accuracy_sse_evaluator
    import ase_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int MAX_FRAMES   = MAX_FRAMES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KIND_W-1:0] cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam int POS_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_ELEMENTS - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAMES);

    // config
    logic [KIND_W-1:0] value_kind_reg;

    // element position counter (advanced at request acceptance)
    logic [POS_W-1:0] pos_cnt_reg;
    logic [POS_W-1:0] pos_cnt_next;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic move1, move2, move3, move4, move5;
    logic accept;
    logic out_free;

    // stage 1: captured request
    logic [31:0]        raw1_reg;
    logic signed [31:0] exp1_reg;
    logic               fl1_reg, dl1_reg;
    logic [POS_W-1:0]   pos1_reg;

    // stage 2: comparison value and difference
    logic signed [31:0] cmp2_reg, exp2_reg;
    logic signed [48:0] diff2_reg;
    logic               fl2_reg, dl2_reg;
    logic [POS_W-1:0]   pos2_reg;
    logic signed [31:0] cmp_next;
    logic signed [48:0] fixed_next;

    // stage 3: magnitude
    logic signed [31:0] cmp3_reg, exp3_reg;
    logic [31:0]        mag3_reg;
    logic               big3_reg;
    logic               fl3_reg, dl3_reg;
    logic [POS_W-1:0]   pos3_reg;
    logic [48:0]        mag_next;

    // stage 4: square
    logic signed [31:0] cmp4_reg, exp4_reg;
    logic [63:0]        sq4_reg;
    logic               fl4_reg, dl4_reg;
    logic [POS_W-1:0]   pos4_reg;

    // running frame state
    logic signed [31:0] best_out_val_reg, best_exp_val_reg;
    logic [POS_W-1:0]   best_out_pos_reg, best_exp_pos_reg;
    logic [63:0]        frame_err_reg;
    logic signed [31:0] best_out_val_next, best_exp_val_next;
    logic [POS_W-1:0]   best_out_pos_next, best_exp_pos_next;
    logic [63:0]        frame_err_next;
    logic [64:0]        frame_sum;

    // stage 5: frame close
    logic        hit5_reg;
    logic [63:0] ferr5_reg;
    logic        dl5_reg;

    // dataset totals
    logic [CNT_W-1:0] hits_reg, frames_reg;
    logic [CNT_W-1:0] hits_next, frames_next;
    logic [63:0]      err_sum_reg;
    logic [63:0]      err_sum_next;
    logic [64:0]      total_sum;

    result_t result_reg;
    logic    result_valid_reg;

    // ---------------- handshake / flow ----------------
    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign move5        = v5_reg && out_free;
    assign move4        = v4_reg && (!fl4_reg || !v5_reg || move5);
    assign move3        = v3_reg && (!v4_reg || move4);
    assign move2        = v2_reg && (!v3_reg || move3);
    assign move1        = v1_reg && (!v2_reg || move2);
    assign item_ready   = !v1_reg || move1;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- datapath ----------------
    always_comb
    begin
        if (item.frame_last)
            pos_cnt_next = '0;
        else if (pos_cnt_reg < POS_LAST)
            pos_cnt_next = pos_cnt_reg + 1'b1;
        else
            pos_cnt_next = pos_cnt_reg;
    end

    // kind conversion: comparison value and Q16.16 value (49 bits, exact)
    always_comb
    begin
        case (value_kind_reg)
            KIND_INT:
            begin
                cmp_next   = $signed(raw1_reg);
                fixed_next = $signed({raw1_reg[31], raw1_reg, 16'b0});
            end
            KIND_BIT:
            begin
                cmp_next   = $signed({31'b0, raw1_reg[31]});
                fixed_next = $signed({32'b0, raw1_reg[31], 16'b0});
            end
            default:
            begin
                cmp_next   = $signed(raw1_reg);
                fixed_next = 49'(cmp_next);
            end
        endcase
    end

    assign mag_next = diff2_reg[48] ? 49'(-diff2_reg) : 49'(diff2_reg);

    // running argmax (first maximum wins) and frame error
    assign frame_sum = {1'b0, frame_err_reg} + {1'b0, sq4_reg};

    always_comb
    begin
        best_out_val_next = best_out_val_reg;
        best_out_pos_next = best_out_pos_reg;
        best_exp_val_next = best_exp_val_reg;
        best_exp_pos_next = best_exp_pos_reg;
        frame_err_next    = frame_sum[64] ? '1 : frame_sum[63:0];
        if (pos4_reg == '0)
        begin
            best_out_val_next = cmp4_reg;
            best_out_pos_next = '0;
            best_exp_val_next = exp4_reg;
            best_exp_pos_next = '0;
            frame_err_next    = sq4_reg;
        end
        else
        begin
            if (cmp4_reg > best_out_val_reg)
            begin
                best_out_val_next = cmp4_reg;
                best_out_pos_next = pos4_reg;
            end
            if (exp4_reg > best_exp_val_reg)
            begin
                best_exp_val_next = exp4_reg;
                best_exp_pos_next = pos4_reg;
            end
        end
    end

    // dataset totals at frame close
    assign total_sum    = {1'b0, err_sum_reg} + {1'b0, ferr5_reg};
    assign err_sum_next = total_sum[64] ? '1 : total_sum[63:0];
    assign frames_next  = (frames_reg >= CNT_LIMIT) ? CNT_LIMIT : frames_reg + 1'b1;

    always_comb
    begin
        hits_next = hits_reg;
        if (hit5_reg)
            hits_next = (hits_reg >= CNT_LIMIT) ? CNT_LIMIT : hits_reg + 1'b1;
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_kind_reg   <= KIND_FIXED;
            pos_cnt_reg      <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            best_out_val_reg <= '0;
            best_out_pos_reg <= '0;
            best_exp_val_reg <= '0;
            best_exp_pos_reg <= '0;
            frame_err_reg    <= '0;
            hits_reg         <= '0;
            frames_reg       <= '0;
            err_sum_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                value_kind_reg <= cfg_data;
            if (accept)
                pos_cnt_reg <= pos_cnt_next;

            if (item_ready)
                v1_reg <= item_valid;
            if (!v2_reg || move2)
                v2_reg <= move1;
            if (!v3_reg || move3)
                v3_reg <= move2;
            if (!v4_reg || move4)
                v4_reg <= move3;
            if (!v5_reg || move5)
                v5_reg <= move4 && fl4_reg;

            if (move4)
            begin
                best_out_val_reg <= best_out_val_next;
                best_out_pos_reg <= best_out_pos_next;
                best_exp_val_reg <= best_exp_val_next;
                best_exp_pos_reg <= best_exp_pos_next;
                frame_err_reg    <= fl4_reg ? '0 : frame_err_next;
            end

            if (move5)
            begin
                result_valid_reg <= 1'b1;
                hits_reg         <= dl5_reg ? '0 : hits_next;
                frames_reg       <= dl5_reg ? '0 : frames_next;
                err_sum_reg      <= dl5_reg ? '0 : err_sum_next;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (item_ready)
        begin
            raw1_reg <= item.raw_output;
            exp1_reg <= item.expected_value;
            fl1_reg  <= item.frame_last;
            dl1_reg  <= item.dataset_last;
            pos1_reg <= pos_cnt_reg;
        end
        if (!v2_reg || move2)
        begin
            cmp2_reg  <= cmp_next;
            exp2_reg  <= exp1_reg;
            diff2_reg <= fixed_next - 49'(exp1_reg);
            fl2_reg   <= fl1_reg;
            dl2_reg   <= dl1_reg;
            pos2_reg  <= pos1_reg;
        end
        if (!v3_reg || move3)
        begin
            cmp3_reg <= cmp2_reg;
            exp3_reg <= exp2_reg;
            mag3_reg <= mag_next[31:0];
            big3_reg <= |mag_next[48:32];
            fl3_reg  <= fl2_reg;
            dl3_reg  <= dl2_reg;
            pos3_reg <= pos2_reg;
        end
        if (!v4_reg || move4)
        begin
            cmp4_reg <= cmp3_reg;
            exp4_reg <= exp3_reg;
            sq4_reg  <= big3_reg ? '1 : 64'(mag3_reg) * 64'(mag3_reg);
            fl4_reg  <= fl3_reg;
            dl4_reg  <= dl3_reg;
            pos4_reg <= pos3_reg;
        end
        if (!v5_reg || move5)
        begin
            hit5_reg  <= (best_out_pos_next == best_exp_pos_next);
            ferr5_reg <= frame_err_next;
            dl5_reg   <= dl4_reg;
        end
        if (move5)
        begin
            result_reg.frame_hit    <= hit5_reg;
            result_reg.hit_count    <= COUNT_OUT_W'(hits_next);
            result_reg.frame_count  <= COUNT_OUT_W'(frames_next);
            result_reg.error_total  <= err_sum_next;
            result_reg.dataset_done <= dl5_reg;
        end
    end

`ifndef SYNTHESIS
    // hits never outrun frames
    a_hits_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= frames_reg)
        else $error("hit count above frame count");

    a_frames_limit: assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= CNT_LIMIT)
        else $error("frame count beyond limit");

    // a frame-last request restarts the position count
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.frame_last |=> pos_cnt_reg == '0)
        else $error("position not cleared after frame end");

    // dataset close clears the totals
    a_dataset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        move5 && dl5_reg |=> frames_reg == '0 && hits_reg == '0 && err_sum_reg == '0)
        else $error("totals not cleared at dataset end");

    // a blocked frame-last request stays in stage 4
    a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !move4 |=> v4_reg && $stable(pos4_reg))
        else $error("stage 4 request lost while blocked");
`endif

endmodule
